// ----- rtl/stcv_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the staged transfer verifier.
package stcv_pkg;

	localparam int LENGTH_BITS_DEFAULT = 32;
	localparam int SESSIONS = 2;

	localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
	localparam logic [31:0] CRC_ONES = 32'hffff_ffff;

	localparam logic [31:0] INSTALL_MAX_RESET = 32'd1048576;
	localparam logic [31:0] TEMP_MAX_RESET = 32'd262144;
	localparam logic [7:0] NAME_CAP_RESET = 8'd32;

	localparam int ADDR_BITS = 4;

	localparam logic [1:0] REG_INSTALL_MAX = 2'd0;
	localparam logic [1:0] REG_TEMP_MAX = 2'd1;
	localparam logic [1:0] REG_NAME_CAP = 2'd2;

	typedef enum logic [1:0] {
		REQ_BEGIN = 2'd0,
		REQ_CHUNK = 2'd1,
		REQ_DATA = 2'd2,
		REQ_COMMIT = 2'd3
	} req_t;

	typedef struct packed {
		logic [31:0] install_max;
		logic [31:0] temp_max;
		logic [7:0] name_cap;
	} cfg_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// ----- rtl/stcv_cfg.sv -----
// Configuration register file behind the APB-style port.
module stcv_cfg import stcv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output cfg_t                 cfg
);

	logic [31:0] install_max_q;
	logic [31:0] temp_max_q;
	logic [7:0]  name_cap_q;
	logic [1:0]  reg_idx;
	logic        wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			install_max_q <= INSTALL_MAX_RESET;
			temp_max_q <= TEMP_MAX_RESET;
			name_cap_q <= NAME_CAP_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_INSTALL_MAX: install_max_q <= pwdata;
				REG_TEMP_MAX: temp_max_q <= pwdata;
				REG_NAME_CAP: name_cap_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_INSTALL_MAX: prdata = install_max_q;
			REG_TEMP_MAX: prdata = temp_max_q;
			REG_NAME_CAP: prdata = {24'd0, name_cap_q};
			default: prdata = 32'd0;
		endcase
	end

	assign cfg = '{install_max: install_max_q, temp_max: temp_max_q, name_cap: name_cap_q};

endmodule

// ----- rtl/staged_transfer_crc_verifier_unit.sv -----
// Top level: request register, session state update and result register of the verifier.
// The request register holds each request; its result goes into the result register.
// Throughput: one request per cycle; a request with a result stalls behind a held one.
// Requests whose chunk stays open give no result and never stall.
// Reset: asynchronous, active low; closes both sessions, clears all counts and CRCs,
// and loads the register defaults. No clearing pass follows.
module staged_transfer_crc_verifier_unit import stcv_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           req_type,
	input  logic                 session_sel,
	input  logic [7:0]           name_len,
	input  logic [31:0]          total_length,
	input  logic [63:0]          expected_check,
	input  logic [31:0]          start_offset,
	input  logic                 offset_present,
	input  logic [15:0]          chunk_length,
	input  logic                 bytes_present,
	input  logic [7:0]           data_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 status,
	output logic [1:0]           answered_type,
	output logic [31:0]          received_count
);

	localparam int CW = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;
	localparam logic [CW-1:0] LEN_MASK = {{(CW-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

	cfg_t cfg;

	stcv_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	assign pready = 1'b1;

	// request register
	logic        valid_s1;
	req_t        type_s1;
	logic        sel_s1;
	logic [7:0]  name_len_s1;
	logic [31:0] total_s1;
	logic [63:0] expect_s1;
	logic [31:0] offs_s1;
	logic        offs_pres_s1;
	logic [15:0] clen_s1;
	logic        bytes_pres_s1;
	logic [7:0]  dbyte_s1;

	// session state
	logic                   active_q [SESSIONS];
	logic [LENGTH_BITS-1:0] total_q [SESSIONS];
	logic [31:0]            expected_q [SESSIONS];
	logic [31:0]            crc_q [SESSIONS];
	logic [LENGTH_BITS-1:0] rcv_q [SESSIONS];
	logic                   chunk_open_q;
	logic [15:0]            chunk_rem_q;
	logic                   chunk_sess_q;

	logic                   active_d [SESSIONS];
	logic [LENGTH_BITS-1:0] total_d [SESSIONS];
	logic [31:0]            expected_d [SESSIONS];
	logic [31:0]            crc_d [SESSIONS];
	logic [LENGTH_BITS-1:0] rcv_d [SESSIONS];
	logic                   chunk_open_d;
	logic [15:0]            chunk_rem_d;
	logic                   chunk_sess_d;

	// result register
	logic        res_valid_s2;
	logic        status_s2;
	logic [1:0]  ans_s2;
	logic [31:0] count_s2;

	logic        produce;
	logic        res_status;
	req_t        res_ans;
	logic        rs;
	logic        advance;
	logic [31:0] max_bytes;
	logic [15:0] rem_dec;

	assign advance = valid_s1 && (!produce || !res_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		active_d = active_q;
		total_d = total_q;
		expected_d = expected_q;
		crc_d = crc_q;
		rcv_d = rcv_q;
		chunk_open_d = chunk_open_q;
		chunk_rem_d = chunk_rem_q;
		chunk_sess_d = chunk_sess_q;
		produce = 1'b1;
		res_status = 1'b0;
		res_ans = type_s1;
		rs = sel_s1;
		max_bytes = sel_s1 ? cfg.temp_max : cfg.install_max;
		rem_dec = chunk_rem_q - 16'd1;
		if (type_s1 == REQ_DATA) begin
			if (!chunk_open_q) begin
				res_status = 1'b1;
			end else begin
				rs = chunk_sess_q;
				crc_d[chunk_sess_q] = crc_byte(crc_q[chunk_sess_q], dbyte_s1);
				rcv_d[chunk_sess_q] = rcv_q[chunk_sess_q] + LENGTH_BITS'(1);
				chunk_rem_d = rem_dec;
				if (rem_dec != 16'd0) begin
					produce = 1'b0;
				end else begin
					chunk_open_d = 1'b0;
					res_ans = REQ_CHUNK;
				end
			end
		end else begin
			chunk_open_d = 1'b0;
			chunk_rem_d = 16'd0;
			unique case (type_s1)
				REQ_BEGIN: begin
					if (name_len_s1 == 8'd0 || name_len_s1 >= cfg.name_cap
						|| expect_s1[63:32] != 32'd0 || total_s1 == 32'd0
						|| total_s1 > max_bytes || CW'(total_s1) > LEN_MASK) begin
						res_status = 1'b1;
					end else begin
						active_d[sel_s1] = 1'b1;
						total_d[sel_s1] = LENGTH_BITS'(total_s1);
						expected_d[sel_s1] = expect_s1[31:0];
						crc_d[sel_s1] = CRC_ONES;
						rcv_d[sel_s1] = '0;
					end
				end
				REQ_CHUNK: begin
					if (!active_q[sel_s1] || !offs_pres_s1 || !bytes_pres_s1
						|| CW'(offs_s1) != CW'(rcv_q[sel_s1])
						|| CW'(rcv_q[sel_s1]) + CW'(clen_s1) > CW'(total_q[sel_s1])) begin
						res_status = 1'b1;
					end else if (clen_s1 != 16'd0) begin
						chunk_open_d = 1'b1;
						chunk_rem_d = clen_s1;
						chunk_sess_d = sel_s1;
						produce = 1'b0;
					end
				end
				default: begin
					if (!active_q[sel_s1] || rcv_q[sel_s1] != total_q[sel_s1]
						|| ~crc_q[sel_s1] != expected_q[sel_s1]) begin
						res_status = 1'b1;
					end else if (!sel_s1) begin
						active_d[0] = 1'b0;
						total_d[0] = '0;
						expected_d[0] = 32'd0;
						crc_d[0] = 32'd0;
						rcv_d[0] = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			type_s1 <= req_t'(req_type);
			sel_s1 <= session_sel;
			name_len_s1 <= name_len;
			total_s1 <= total_length;
			expect_s1 <= expected_check;
			offs_s1 <= start_offset;
			offs_pres_s1 <= offset_present;
			clen_s1 <= chunk_length;
			bytes_pres_s1 <= bytes_present;
			dbyte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SESSIONS; s++) begin
				active_q[s] <= 1'b0;
				total_q[s] <= '0;
				expected_q[s] <= 32'd0;
				crc_q[s] <= 32'd0;
				rcv_q[s] <= '0;
			end
			chunk_open_q <= 1'b0;
			chunk_rem_q <= 16'd0;
			chunk_sess_q <= 1'b0;
		end else if (advance) begin
			active_q <= active_d;
			total_q <= total_d;
			expected_q <= expected_d;
			crc_q <= crc_d;
			rcv_q <= rcv_d;
			chunk_open_q <= chunk_open_d;
			chunk_rem_q <= chunk_rem_d;
			chunk_sess_q <= chunk_sess_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && produce) begin
			res_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			status_s2 <= res_status;
			ans_s2 <= res_ans;
			count_s2 <= 32'(rcv_d[rs]);
		end
	end

	assign out_valid = res_valid_s2;
	assign status = status_s2;
	assign answered_type = ans_s2;
	assign received_count = count_s2;

`ifndef SYNTHESIS
	a_chunk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_open_q |-> chunk_rem_q != 16'd0)
		else $error("open chunk with no bytes remaining");

	a_rcv_within_total0: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_q[0] <= total_q[0])
		else $error("install session received more than its total");

	a_rcv_within_total1: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_q[1] <= total_q[1])
		else $error("temporary session received more than its total");

	a_stray_data_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && ans_s2 == REQ_DATA |-> status_s2)
		else $error("data byte answered ok");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(type_s1) && $stable(sel_s1))
		else $error("stalled request lost");
`endif

endmodule
